// ===== sv/opsa_pkg.sv =====
// Object pool slot allocator: shared types, command and status codes.
// Used by opsa_free_fifo and object_pool_slot_allocator_top; depends on nothing.
`default_nettype none
package opsa_pkg;

	localparam int SLOTS = 256;
	localparam int HW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW    = $clog2(SLOTS + 1);

	typedef logic [HW-1:0] handle_t;
	typedef logic [CW-1:0] count_t;

	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_TRY   = 2'd1;
	localparam logic [1:0] CMD_FREE  = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NONE      = 2'd1;
	localparam logic [1:0] ST_EXHAUSTED = 2'd2;
	localparam logic [1:0] ST_WRONG     = 2'd3;

	typedef struct packed {
		logic rd_en;
		logic pop;
		logic push;
	} fifo_ctl_t;

	typedef struct packed {
		logic nonempty;
		logic not_full;
	} fifo_sts_t;

endpackage
`default_nettype wire

// ===== sv/opsa_ram.sv =====
// Generic single-write, single-read synchronous RAM, registered read data.
// No dependencies.
`default_nettype none
module opsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/opsa_free_fifo.sv =====
// Released-handle queue: head/tail/count pointers around a RAM.
// Depends on opsa_pkg and opsa_ram.
`default_nettype none
module opsa_free_fifo (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire opsa_pkg::fifo_ctl_t ctl,
	input  wire opsa_pkg::handle_t   push_data,
	output opsa_pkg::handle_t        rd_data,
	output opsa_pkg::fifo_sts_t      sts
);

	opsa_pkg::handle_t head_q;
	opsa_pkg::handle_t tail_q;
	opsa_pkg::count_t  count_q;

	function automatic opsa_pkg::handle_t wrap_next(input opsa_pkg::handle_t i);
		if (32'(i) == opsa_pkg::SLOTS - 1) begin
			return '0;
		end
		return i + opsa_pkg::HW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop) begin
				head_q <= wrap_next(head_q);
			end
			if (ctl.push) begin
				tail_q <= wrap_next(tail_q);
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + opsa_pkg::CW'(1);
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - opsa_pkg::CW'(1);
			end
		end
	end

	assign sts.nonempty = (count_q != '0);
	assign sts.not_full = (count_q != opsa_pkg::CW'(opsa_pkg::SLOTS));

	// head entry is read when an item is taken (rd_en); it is consumed by the later pop
	opsa_ram #(
		.WIDTH(opsa_pkg::HW),
		.DEPTH(opsa_pkg::SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ctl.push),
		.waddr (tail_q),
		.wdata (push_data),
		.re    (ctl.rd_en),
		.raddr (head_q),
		.rdata (rd_data)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.pop |-> (count_q != '0))
		else $error("pop from empty release queue");

	a_push_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.push |-> (count_q != opsa_pkg::CW'(opsa_pkg::SLOTS)))
		else $error("push into full release queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= opsa_pkg::SLOTS)
		else $error("release queue count beyond pool size");

endmodule
`default_nettype wire

// ===== sv/object_pool_slot_allocator_top.sv =====
// Object pool slot allocator, top level. Depends on opsa_pkg, opsa_ram, opsa_free_fifo.
// Path: an accepted beat is held in s1; its result is loaded into the output register when s1 retires.
// Interlock: no new beat is taken while s1 holds one, because of the read-modify-write
//   on the allocated-bit RAM and the release-queue RAM (read at accept, write in s1).
// Reset: arst_n clears pointers, counters and valid flags at once; the RAMs are
//   not swept, so the block takes beats from the first cycle after reset.
`default_nettype none
module object_pool_slot_allocator_top (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [1:0] command,
	input  wire logic [7:0] handle_in,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      handle_out,
	output logic [1:0]      status
);

	// Stage s1 holds the beat while its RAM reads come back.
	logic              valid_s1;
	logic [1:0]        cmd_s1;
	logic [7:0]        handle_s1;

	// Handles below fresh_count_q have been issued at least once, so their
	// allocated bit has been written; at and above it the bit is unwritten and is not trusted.
	opsa_pkg::count_t  fresh_count_q;

	logic              out_valid_q;
	logic [7:0]        handle_out_q;
	logic [1:0]        status_q;

	logic              accept;
	logic              done;

	logic              bm_rd;
	logic              bm_we;
	logic              bm_wdata;
	opsa_pkg::handle_t bm_waddr;

	opsa_pkg::fifo_ctl_t q_ctl;
	opsa_pkg::fifo_sts_t q_sts;
	opsa_pkg::handle_t   q_rd;

	logic              pop;
	logic              push;
	logic              fresh_inc;
	logic              owned;
	opsa_pkg::handle_t hout;
	logic [1:0]        st;

	// Interlock: nothing new enters while s1 is busy, so a read never
	// overtakes the write-back of the beat ahead of it.
	assign in_stall = valid_s1;
	assign accept   = in_valid && !valid_s1;

	// s1 retires when the output register is free or being emptied.
	assign done = valid_s1 && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (done) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1    <= command;
			handle_s1 <= handle_in;
		end
	end

	// Deallocate is only legal for a handle already issued with its bit set.
	assign owned = bm_rd && (32'(handle_s1) < 32'(fresh_count_q));

	// Decision logic for the beat in s1.
	always_comb begin
		st        = opsa_pkg::ST_OK;
		hout      = '0;
		bm_we     = 1'b0;
		bm_wdata  = 1'b0;
		bm_waddr  = opsa_pkg::HW'(handle_s1);
		pop       = 1'b0;
		push      = 1'b0;
		fresh_inc = 1'b0;
		case (cmd_s1)
			opsa_pkg::CMD_ALLOC, opsa_pkg::CMD_TRY: begin
				if (q_sts.nonempty) begin
					// oldest released handle first
					pop      = 1'b1;
					hout     = q_rd;
					bm_we    = 1'b1;
					bm_wdata = 1'b1;
					bm_waddr = q_rd;
				end else if (cmd_s1 == opsa_pkg::CMD_TRY) begin
					st = opsa_pkg::ST_NONE;
				end else if (fresh_count_q != opsa_pkg::CW'(opsa_pkg::SLOTS)) begin
					fresh_inc = 1'b1;
					hout      = opsa_pkg::HW'(fresh_count_q);
					bm_we     = 1'b1;
					bm_wdata  = 1'b1;
					bm_waddr  = opsa_pkg::HW'(fresh_count_q);
				end else begin
					st = opsa_pkg::ST_EXHAUSTED;
				end
			end
			opsa_pkg::CMD_FREE: begin
				if (owned) begin
					bm_we = 1'b1;
					push  = q_sts.not_full;
				end else begin
					st = opsa_pkg::ST_WRONG;
				end
			end
			default: begin
				// unused command code: no change, answers ok
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fresh_count_q <= '0;
		end else if (done && fresh_inc) begin
			fresh_count_q <= fresh_count_q + opsa_pkg::CW'(1);
		end
	end

	// Output register: parts s1 from the downstream stall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			handle_out_q <= 8'(hout);
			status_q     <= st;
		end
	end

	assign out_valid  = out_valid_q;
	assign handle_out = handle_out_q;
	assign status     = status_q;

	// Allocated-bit RAM: read at accept, written back when s1 retires.
	opsa_ram #(
		.WIDTH(1),
		.DEPTH(opsa_pkg::SLOTS)
	) u_bitmap (
		.clk   (clk),
		.we    (bm_we && done),
		.waddr (bm_waddr),
		.wdata (bm_wdata),
		.re    (accept),
		.raddr (opsa_pkg::HW'(handle_in)),
		.rdata (bm_rd)
	);

	assign q_ctl.rd_en = accept;
	assign q_ctl.pop   = pop && done;
	assign q_ctl.push  = push && done;

	opsa_free_fifo u_free_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (q_ctl),
		.push_data (opsa_pkg::HW'(handle_s1)),
		.rd_data   (q_rd),
		.sts       (q_sts)
	);

	a_fresh_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fresh_count_q) <= opsa_pkg::SLOTS)
		else $error("fresh counter beyond pool size");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> valid_s1)
		else $error("accepted beat lost before s1");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
			(out_valid && $stable(handle_out) && $stable(status)))
		else $error("stalled result beat changed");

endmodule
`default_nettype wire
